// ----- rtl/core/tpsd_pkg.sv -----
// shared types and constants of the tga pixel stream decoder
`default_nettype none

package tpsd_pkg;

   // size registers and the configuration port
   localparam int SIZE_W             = 13;
   localparam int CSR_INDEX_W        = 3;
   localparam int DEFAULT_MAX_WIDTH  = 4096;
   localparam int DEFAULT_MAX_HEIGHT = 4096;

   // depth of the queue between front and back end
   localparam int QUEUE_DEPTH = 4;

   // output position field width
   localparam int POS_OUT_W = 12;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_FOUR_BYTE_PIXELS = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_RLE_ENABLE       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_FLIP_ROWS        = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH      = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT     = 3'd4;

   // packet header layout and the alpha of 24-bit pixels
   localparam int             HDR_REPEAT_BIT = 7;
   localparam logic [6:0]     HDR_COUNT_MASK = 7'h7F;
   localparam logic [7:0]     OPAQUE_ALPHA   = 8'hFF;

   typedef struct packed {
      logic              four_byte_pixels;
      logic              rle_enable;
      logic              flip_rows;
      logic              restart;
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
   } cfg_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] run_length;
      logic       image_done;
   } qentry_type;

endpackage

`default_nettype wire

// ----- rtl/core/tpsd_front.sv -----
// front end: packet headers, pixel gathering, run clipping and end of image
`default_nettype none

module tpsd_front #(
   parameter int MAX_WIDTH  = tpsd_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = tpsd_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tpsd_pkg::cfg_type    cfg,
   input  wire logic                 byte_take,
   input  wire logic [7:0]           data_byte,
   output logic                      push,
   output tpsd_pkg::qentry_type      push_entry
);

   localparam int SIZE_LIM = (1 << tpsd_pkg::SIZE_W) - 1;
   localparam int W_LIM    = (MAX_WIDTH < SIZE_LIM) ? MAX_WIDTH : SIZE_LIM;
   localparam int H_LIM    = (MAX_HEIGHT < SIZE_LIM) ? MAX_HEIGHT : SIZE_LIM;
   localparam int LEFT_W   = $clog2(W_LIM * H_LIM + 1);
   localparam int AREA_W   = 2 * tpsd_pkg::SIZE_W;

   logic              expect_ff,  expect_in;
   logic              repeat_ff,  repeat_in;
   logic [7:0]        packet_left_ff, packet_left_in;
   logic [1:0]        bip_ff,     bip_in;
   logic [23:0]       pixel_ff,   pixel_in;
   logic [LEFT_W-1:0] left_ff,    left_in;
   logic              fresh_ff,   fresh_in;
   logic [LEFT_W-1:0] area_ff,    area_in;

   logic [AREA_W-1:0] area_full;
   logic [1:0]        last_byte;
   logic              is_header;
   logic              is_end;
   logic [LEFT_W-1:0] left_cur;
   logic [LEFT_W-1:0] left_after;
   logic [7:0]        run_raw;
   logic [7:0]        run_len;
   logic              done;

   assign area_full = AREA_W'(cfg.width) * AREA_W'(cfg.height);
   assign area_in   = LEFT_W'(area_full);

   assign last_byte  = cfg.four_byte_pixels ? 2'd3 : 2'd2;
   assign is_header  = cfg.rle_enable & expect_ff;
   assign is_end     = ~is_header & (bip_ff == last_byte);
   assign left_cur   = fresh_ff ? area_ff : left_ff;
   assign run_raw    = (cfg.rle_enable & repeat_ff) ? packet_left_ff : 8'd1;
   assign run_len    = (LEFT_W'(run_raw) > left_cur) ? 8'(left_cur) : run_raw;
   assign left_after = left_cur - LEFT_W'(run_len);
   assign done       = (left_after == '0);

   assign push = byte_take & is_end;

   always_comb begin
      push_entry.blue       = pixel_ff[7:0];
      push_entry.green      = pixel_ff[15:8];
      push_entry.red        = cfg.four_byte_pixels ? pixel_ff[23:16] : data_byte;
      push_entry.alpha      = cfg.four_byte_pixels ? data_byte : tpsd_pkg::OPAQUE_ALPHA;
      push_entry.run_length = run_len;
      push_entry.image_done = done;
   end

   always_comb begin
      expect_in      = expect_ff;
      repeat_in      = repeat_ff;
      packet_left_in = packet_left_ff;
      bip_in         = bip_ff;
      pixel_in       = pixel_ff;
      left_in        = left_ff;
      fresh_in       = fresh_ff;
      if (cfg.restart) begin
         expect_in      = 1'b1;
         repeat_in      = 1'b0;
         packet_left_in = 8'd0;
         bip_in         = 2'd0;
         pixel_in       = 24'd0;
         fresh_in       = 1'b1;
      end else if (byte_take) begin
         if (is_header) begin
            repeat_in      = data_byte[tpsd_pkg::HDR_REPEAT_BIT];
            packet_left_in = {1'b0, data_byte[6:0] & tpsd_pkg::HDR_COUNT_MASK} + 8'd1;
            expect_in      = 1'b0;
         end else if (!is_end) begin
            pixel_in[8*bip_ff +: 8] = data_byte;
            bip_in                  = bip_ff + 2'd1;
         end else begin
            pixel_in = 24'd0;
            bip_in   = 2'd0;
            left_in  = left_after;
            fresh_in = 1'b0;
            if (cfg.rle_enable) begin
               if (repeat_ff) begin
                  expect_in = 1'b1;
               end else begin
                  packet_left_in = packet_left_ff - 8'd1;
                  if (packet_left_ff == 8'd1) begin
                     expect_in = 1'b1;
                  end
               end
            end
            // last pixel of the image: start over on the next byte
            if (done) begin
               expect_in      = 1'b1;
               repeat_in      = 1'b0;
               packet_left_in = 8'd0;
               fresh_in       = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_ff      <= 1'b1;
         repeat_ff      <= 1'b0;
         packet_left_ff <= 8'd0;
         bip_ff         <= 2'd0;
         pixel_ff       <= 24'd0;
         fresh_ff       <= 1'b1;
      end else begin
         expect_ff      <= expect_in;
         repeat_ff      <= repeat_in;
         packet_left_ff <= packet_left_in;
         bip_ff         <= bip_in;
         pixel_ff       <= pixel_in;
         fresh_ff       <= fresh_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff <= left_in;
      area_ff <= area_in;
   end

endmodule

`default_nettype wire

// ----- rtl/core/tpsd_queue.sv -----
// short queue of decoded runs between front and back end
`default_nettype none

module tpsd_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire tpsd_pkg::qentry_type push_entry,
   input  wire logic                 pop,
   output logic                      full,
   output logic                      not_empty,
   output tpsd_pkg::qentry_type      head
);

   localparam int PTR_W = $clog2(tpsd_pkg::QUEUE_DEPTH);
   localparam int CNT_W = PTR_W + 1;

   tpsd_pkg::qentry_type slot_ff [tpsd_pkg::QUEUE_DEPTH];

   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff,  count_in;

   assign full      = (count_ff == CNT_W'(tpsd_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/tpsd_back.sv -----
// back end: run placement, row wrap by iterative division and result register
`default_nettype none

module tpsd_back #(
   parameter int MAX_WIDTH  = tpsd_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = tpsd_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tpsd_pkg::cfg_type    cfg,
   input  wire logic                 head_valid,
   input  wire tpsd_pkg::qentry_type head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output tpsd_pkg::qentry_type      rsp_entry,
   output logic [tpsd_pkg::POS_OUT_W-1:0] rsp_column,
   output logic [tpsd_pkg::POS_OUT_W-1:0] rsp_row
);

   localparam int SIZE_LIM = (1 << tpsd_pkg::SIZE_W) - 1;
   localparam int W_LIM    = (MAX_WIDTH < SIZE_LIM) ? MAX_WIDTH : SIZE_LIM;
   localparam int H_LIM    = (MAX_HEIGHT < SIZE_LIM) ? MAX_HEIGHT : SIZE_LIM;
   localparam int COL_W    = $clog2(W_LIM);
   localparam int ROW_W    = $clog2(H_LIM);
   localparam int HT_W     = $clog2(H_LIM + 1);
   localparam int T_W      = COL_W + 1;
   localparam int POS_W    = ((COL_W > 8) ? COL_W : 8) + 1;
   localparam int OUT_W    = tpsd_pkg::POS_OUT_W;

   logic                 busy_ff,  busy_in;
   logic [COL_W-1:0]     rem_ff,   rem_in;
   logic [3:0]           low_ff,   low_in;
   logic [3:0]           qhi_ff,   qhi_in;
   logic [COL_W-1:0]     col_ff,   col_in;
   logic [ROW_W-1:0]     row_ff,   row_in;
   logic                 valid_ff, valid_in;
   tpsd_pkg::qentry_type entry_ff, entry_in;
   logic [OUT_W-1:0]     ocol_ff,  ocol_in;
   logic [OUT_W-1:0]     orow_ff,  orow_in;

   logic [POS_W-1:0] pos;
   logic [HT_W-1:0]  row_flip;
   logic [COL_W-1:0] div_r_start;
   logic [3:0]       div_bits;
   logic [COL_W-1:0] div_r;
   logic [T_W-1:0]   div_t;
   logic [3:0]       div_q;

   assign pop      = head_valid & ~busy_ff & (~valid_ff | ~rsp_stall);
   assign pos      = POS_W'(col_ff) + POS_W'(head.run_length);
   assign row_flip = HT_W'(cfg.height) - HT_W'(1) - HT_W'(row_ff);

   // four restoring steps a cycle: high quotient bits at pop, low ones next cycle
   assign div_r_start = busy_ff ? rem_ff : COL_W'(pos >> 8);
   assign div_bits    = busy_ff ? low_ff : pos[7:4];

   always_comb begin
      div_r = div_r_start;
      div_t = '0;
      div_q = 4'd0;
      for (int i = 3; i >= 0; i--) begin
         div_t = {div_r, div_bits[i]};
         if (div_t >= T_W'(cfg.width)) begin
            div_t    = div_t - T_W'(cfg.width);
            div_q[i] = 1'b1;
         end
         div_r = div_t[COL_W-1:0];
      end
   end

   always_comb begin
      busy_in  = busy_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      qhi_in   = qhi_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      entry_in = entry_ff;
      ocol_in  = ocol_ff;
      orow_in  = orow_ff;
      valid_in = valid_ff & rsp_stall;
      if (cfg.restart) begin
         busy_in = 1'b0;
         col_in  = '0;
         row_in  = '0;
      end else if (pop) begin
         valid_in = 1'b1;
         entry_in = head;
         ocol_in  = OUT_W'(col_ff);
         orow_in  = cfg.flip_rows ? OUT_W'(row_flip) : OUT_W'(row_ff);
         if (head.image_done) begin
            col_in = '0;
            row_in = '0;
         end else begin
            busy_in = 1'b1;
            rem_in  = div_r;
            low_in  = pos[3:0];
            qhi_in  = div_q;
         end
      end else if (busy_ff) begin
         busy_in = 1'b0;
         col_in  = div_r;
         row_in  = row_ff + ROW_W'({qhi_ff, div_q});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         col_ff   <= '0;
         row_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      low_ff   <= low_in;
      qhi_ff   <= qhi_in;
      entry_ff <= entry_in;
      ocol_ff  <= ocol_in;
      orow_ff  <= orow_in;
   end

   assign rsp_valid  = valid_ff;
   assign rsp_entry  = entry_ff;
   assign rsp_column = ocol_ff;
   assign rsp_row    = orow_ff;

endmodule

`default_nettype wire

// ----- rtl/core/tga_pixel_stream_decoder.sv -----
// top level of the tga pixel stream decoder: registers, front end, queue, back end
`default_nettype none

// Takes TGA pixel data (raw or RLE packets, 24- or 32-bit pixels) one byte
// per request and gives one result per completed pixel: RGBA, the column and
// destination row of the run's first pixel, the run length and an end of image
// mark. The request side takes one byte per cycle while req_stall is low. The
// back end places a run by a four-bit-per-cycle division for the row wrap, and
// a pixel always spans at least three bytes, so a four-entry queue keeps the
// request side running at full rate while the result side is not stalled.
// After reset and after each write to indexes 0 to 4 (each starts a new image)
// the request side stalls while the image area product is registered. The user
// writes registers only when the block is idle; the block does not enforce it.

module tga_pixel_stream_decoder #(
   parameter int MAX_WIDTH  = tpsd_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = tpsd_pkg::DEFAULT_MAX_HEIGHT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [tpsd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [tpsd_pkg::SIZE_W-1:0]      csr_wdata,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_data_byte,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [7:0]                            rsp_red,
   output logic [7:0]                            rsp_green,
   output logic [7:0]                            rsp_blue,
   output logic [7:0]                            rsp_alpha,
   output logic [tpsd_pkg::POS_OUT_W-1:0]        rsp_start_column,
   output logic [tpsd_pkg::POS_OUT_W-1:0]        rsp_dest_row,
   output logic [7:0]                            rsp_run_length,
   output logic                                  rsp_image_done
);

   localparam int SW       = tpsd_pkg::SIZE_W;
   localparam int SIZE_LIM = (1 << SW) - 1;
   localparam int W_LIM    = (MAX_WIDTH < SIZE_LIM) ? MAX_WIDTH : SIZE_LIM;
   localparam int H_LIM    = (MAX_HEIGHT < SIZE_LIM) ? MAX_HEIGHT : SIZE_LIM;

   logic          four_ff,   four_in;
   logic          rle_ff,    rle_in;
   logic          flip_ff,   flip_in;
   logic [SW-1:0] width_ff,  width_in;
   logic [SW-1:0] height_ff, height_in;
   logic          settle_ff, settle_in;

   logic                 csr_write;
   logic                 restart;
   tpsd_pkg::cfg_type    cfg;
   logic                 byte_take;
   logic                 push;
   tpsd_pkg::qentry_type push_entry;
   logic                 pop;
   logic                 q_full;
   logic                 q_not_empty;
   tpsd_pkg::qentry_type q_head;
   tpsd_pkg::qentry_type rsp_entry;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   always_comb begin
      four_in   = four_ff;
      rle_in    = rle_ff;
      flip_in   = flip_ff;
      width_in  = width_ff;
      height_in = height_ff;
      restart   = 1'b0;
      if (csr_write) begin
         case (csr_index)
            tpsd_pkg::REG_FOUR_BYTE_PIXELS: begin
               four_in = csr_wdata[0];
               restart = 1'b1;
            end
            tpsd_pkg::REG_RLE_ENABLE: begin
               rle_in  = csr_wdata[0];
               restart = 1'b1;
            end
            tpsd_pkg::REG_FLIP_ROWS: begin
               flip_in = csr_wdata[0];
               restart = 1'b1;
            end
            tpsd_pkg::REG_IMAGE_WIDTH: begin
               width_in = csr_wdata;
               restart  = 1'b1;
            end
            tpsd_pkg::REG_IMAGE_HEIGHT: begin
               height_in = csr_wdata;
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
      settle_in = restart;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         four_ff   <= 1'b1;
         rle_ff    <= 1'b1;
         flip_ff   <= 1'b0;
         width_ff  <= SW'(1);
         height_ff <= SW'(1);
         settle_ff <= 1'b1;
      end else begin
         four_ff   <= four_in;
         rle_ff    <= rle_in;
         flip_ff   <= flip_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         settle_ff <= settle_in;
      end
   end

   // zero counts as one, oversize saturates
   always_comb begin
      cfg.four_byte_pixels = four_ff;
      cfg.rle_enable       = rle_ff;
      cfg.flip_rows        = flip_ff;
      cfg.restart          = restart;
      if (width_ff == '0) begin
         cfg.width = SW'(1);
      end else if (width_ff > SW'(W_LIM)) begin
         cfg.width = SW'(W_LIM);
      end else begin
         cfg.width = width_ff;
      end
      if (height_ff == '0) begin
         cfg.height = SW'(1);
      end else if (height_ff > SW'(H_LIM)) begin
         cfg.height = SW'(H_LIM);
      end else begin
         cfg.height = height_ff;
      end
   end

   assign req_stall = settle_ff | q_full;
   assign byte_take = req_valid & ~req_stall;

   tpsd_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .byte_take  (byte_take),
      .data_byte  (req_data_byte),
      .push       (push),
      .push_entry (push_entry)
   );

   tpsd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .not_empty  (q_not_empty),
      .head       (q_head)
   );

   tpsd_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .head_valid (q_not_empty),
      .head       (q_head),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_entry  (rsp_entry),
      .rsp_column (rsp_start_column),
      .rsp_row    (rsp_dest_row)
   );

   assign rsp_red        = rsp_entry.red;
   assign rsp_green      = rsp_entry.green;
   assign rsp_blue       = rsp_entry.blue;
   assign rsp_alpha      = rsp_entry.alpha;
   assign rsp_run_length = rsp_entry.run_length;
   assign rsp_image_done = rsp_entry.image_done;

endmodule

`default_nettype wire
